### rtl/core/midpoint_ellipse_rasterizer_defines.svh
// Assertion macros for the midpoint ellipse rasterizer.
// Used by the top level only; relies on the clock and reset port names.
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_DEFINES_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MER_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define MER_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/mer_pkg.sv
// Shared widths, codes and the command type of the ellipse rasterizer.
// No dependencies; every module file imports it.
package mer_pkg;

   localparam int COORD_BITS  = 11;
   localparam int SEMI_BITS   = 10;
   localparam int CUR_BITS    = SEMI_BITS + 1;
   localparam int SQ_BITS     = 2 * SEMI_BITS;
   localparam int PIX_BITS    = ((COORD_BITS > CUR_BITS) ? COORD_BITS : CUR_BITS) + 2;
   localparam int COLOR_BITS  = 4;
   localparam logic [COLOR_BITS-1:0] COLOR_RESET = 4'hF;
   localparam int DEC_BITS    = 48;
   localparam int TERM_BITS   = SQ_BITS + CUR_BITS + 3;
   localparam int OPA_BITS    = SQ_BITS;
   localparam int OPB_BITS    = 2 * CUR_BITS + 2;
   localparam int PROD_BITS   = OPA_BITS + 1 + OPB_BITS;
   localparam int QUEUE_DEPTH = 2;

   // Request action field codes
   localparam logic ACT_START = 1'b0;
   localparam logic ACT_STEP  = 1'b1;

   typedef enum logic [0:0] {
      CMD_START = 1'b0,
      CMD_STEP  = 1'b1
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type            kind;
      logic [COORD_BITS-1:0]   center_x;
      logic [COORD_BITS-1:0]   center_y;
      logic [SEMI_BITS-1:0]    semi_y;
      logic [SQ_BITS-1:0]      sq_x;
      logic [SQ_BITS-1:0]      sq_y;
   } cmd_type;

endpackage

### rtl/core/mer_front.sv
// Front end: registers each request, classifies it and squares the semi-axes.
// Depends on mer_pkg.
module mer_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_action,
   input  logic [mer_pkg::COORD_BITS-1:0]  req_center_x,
   input  logic [mer_pkg::COORD_BITS-1:0]  req_center_y,
   input  logic [mer_pkg::SEMI_BITS-1:0]   req_semi_x,
   input  logic [mer_pkg::SEMI_BITS-1:0]   req_semi_y,
   output logic                            cmd_valid,
   input  logic                            cmd_ready,
   output mer_pkg::cmd_type                cmd
);
   import mer_pkg::*;

   logic                  stage_valid_ff, stage_valid_in;
   logic                  action_ff;
   logic [COORD_BITS-1:0] cx_ff, cy_ff;
   logic [SEMI_BITS-1:0]  sx_ff, sy_ff;
   logic [SQ_BITS-1:0]    sx_wide, sy_wide;
   logic                  take;

   assign req_ready = !stage_valid_ff || cmd_ready;
   assign take      = req_valid && req_ready;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (take) begin
         stage_valid_in = 1'b1;
      end else if (cmd_ready) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         action_ff <= req_action;
         cx_ff     <= req_center_x;
         cy_ff     <= req_center_y;
         sx_ff     <= req_semi_x;
         sy_ff     <= req_semi_y;
      end
   end

   assign sx_wide = {{(SQ_BITS-SEMI_BITS){1'b0}}, sx_ff};
   assign sy_wide = {{(SQ_BITS-SEMI_BITS){1'b0}}, sy_ff};

   // Squares land in the queue register, so the back end sees them registered.
   assign cmd_valid     = stage_valid_ff;
   assign cmd.kind      = (action_ff == ACT_STEP) ? CMD_STEP : CMD_START;
   assign cmd.center_x  = cx_ff;
   assign cmd.center_y  = cy_ff;
   assign cmd.semi_y    = sy_ff;
   assign cmd.sq_x      = sx_wide * sx_wide;
   assign cmd.sq_y      = sy_wide * sy_wide;

endmodule

### rtl/core/mer_fifo.sv
// Short command queue between the front and the back end.
// Depends on mer_pkg for the command type.
module mer_fifo #(
   parameter int DEPTH = mer_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  mer_pkg::cmd_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output mer_pkg::cmd_type pop_data
);
   import mer_pkg::*;

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);

   cmd_type               entry_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  push, pop;

   assign push_ready = (count_ff != CNT_BITS'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/core/mer_back.sv
// Back end: midpoint iteration on one shared multiplier, then four mirrored pixels.
// Depends on mer_pkg.
module mer_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  cmd_valid,
   output logic                                  cmd_ready,
   input  mer_pkg::cmd_type                      cmd,
   input  logic [mer_pkg::COLOR_BITS-1:0]        draw_color,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [mer_pkg::PIX_BITS-1:0]   pixel_x,
   output logic signed [mer_pkg::PIX_BITS-1:0]   pixel_y,
   output logic [mer_pkg::COLOR_BITS-1:0]        pixel_color,
   output logic                                  last_of_step,
   output logic                                  curve_done
);
   import mer_pkg::*;

   typedef logic signed [DEC_BITS-1:0] dec_type;

   typedef enum logic [13:0] {
      ST_IDLE  = 14'h0001,
      ST_FY    = 14'h0002,
      ST_INIT  = 14'h0004,
      ST_R1    = 14'h0008,
      ST_MAC_Y = 14'h0010,
      ST_ACC   = 14'h0020,
      ST_E0    = 14'h0040,
      ST_E1    = 14'h0080,
      ST_E2    = 14'h0100,
      ST_E3    = 14'h0200,
      ST_E4    = 14'h0400,
      ST_E5    = 14'h0800,
      ST_R2    = 14'h1000,
      ST_EMIT  = 14'h2000
   } state_type;

   localparam logic signed [OPB_BITS-1:0] K2 = OPB_BITS'(2);
   localparam logic signed [OPB_BITS-1:0] K3 = OPB_BITS'(3);

   // Round a quarter-unit value toward zero: floor part plus one when negative
   // and a remainder is left.
   function automatic dec_type quarter_trunc(input dec_type floor_part,
                                             input logic [1:0] rem);
      logic bump;
      bump = floor_part[DEC_BITS-1] && (rem != 2'b00);
      return floor_part + dec_type'(bump);
   endfunction

   state_type                    state_ff, state_in;
   logic [CUR_BITS-1:0]          x_ff, x_in, y_ff, y_in;
   logic signed [TERM_BITS-1:0]  fx_ff, fx_in, fy_ff, fy_in;
   dec_type                      dec_ff, dec_in;
   logic [SQ_BITS-1:0]           sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [COORD_BITS-1:0]        ox_ff, ox_in, oy_ff, oy_in;
   logic                         r2_ff, r2_in;
   logic                         active_ff, active_in;
   logic signed [PROD_BITS-1:0]  prod_ff, prod_in;
   logic signed [OPB_BITS-1:0]   tmp_ff, tmp_in;
   logic [1:0]                   idx_ff, idx_in;

   logic                         out_valid_ff, out_valid_in;
   logic signed [PIX_BITS-1:0]   out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic [COLOR_BITS-1:0]        out_color_ff, out_color_in;
   logic                         out_last_ff, out_last_in;
   logic                         out_done_ff, out_done_in;

   logic [CUR_BITS:0]            x_inc;
   logic [CUR_BITS-1:0]          y_dec;
   logic signed [OPB_BITS-1:0]   x_inc_b, y_b, y_dec_b, sqy_b;
   logic signed [TERM_BITS-1:0]  fx_step, fy_step;
   logic                         r1_go, more, dec_neg, load_pix;
   logic [OPA_BITS-1:0]          mul_a;
   logic signed [OPB_BITS-1:0]   mul_b;
   logic signed [PIX_BITS-1:0]   px_base, py_base, px_off, py_off;
   dec_type                      prod_d, sqy_d, sqx_q, sqy_q;

   assign x_inc   = {1'b0, x_ff} + 1'b1;
   assign y_dec   = y_ff - 1'b1;
   assign x_inc_b = $signed({{(OPB_BITS-CUR_BITS-1){1'b0}}, x_inc});
   assign y_b     = $signed({{(OPB_BITS-CUR_BITS){1'b0}}, y_ff});
   assign y_dec_b = $signed({{(OPB_BITS-CUR_BITS){1'b0}}, y_dec});
   assign sqy_b   = $signed({{(OPB_BITS-SQ_BITS){1'b0}}, sqy_ff});
   assign fx_step = fx_ff + $signed({{(TERM_BITS-SQ_BITS-1){1'b0}}, sqy_ff, 1'b0});
   assign fy_step = fy_ff - $signed({{(TERM_BITS-SQ_BITS-1){1'b0}}, sqx_ff, 1'b0});
   assign r1_go   = !r2_ff && (fx_ff < fy_ff);
   assign more    = r1_go || (y_ff != '0);
   assign dec_neg = dec_ff[DEC_BITS-1];

   assign prod_d  = dec_type'(prod_ff);
   assign sqy_d   = $signed({{(DEC_BITS-SQ_BITS){1'b0}}, sqy_ff});
   assign sqx_q   = $signed({{(DEC_BITS-SQ_BITS+2){1'b0}}, sqx_ff[SQ_BITS-1:2]});
   assign sqy_q   = $signed({{(DEC_BITS-SQ_BITS+2){1'b0}}, sqy_ff[SQ_BITS-1:2]});

   // Operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_FY: begin
            mul_a = sqx_ff;
            mul_b = y_b;
         end
         ST_R1: begin
            mul_a = sqy_ff;
            mul_b = (x_inc_b <<< 1) + K3;
         end
         ST_MAC_Y: begin
            mul_a = sqx_ff;
            mul_b = (r2_ff ? K3 : K2) - (y_b <<< 1);
         end
         ST_E0: begin
            mul_a = OPA_BITS'(x_ff);
            mul_b = x_inc_b;
         end
         ST_E1: begin
            mul_a = OPA_BITS'(y_dec);
            mul_b = y_dec_b;
         end
         ST_E2: begin
            mul_a = sqy_ff;
            mul_b = tmp_ff;
         end
         ST_E3: begin
            mul_a = sqx_ff;
            mul_b = tmp_ff;
         end
         ST_E4: begin
            mul_a = sqx_ff;
            mul_b = sqy_b;
         end
         ST_R2: begin
            if (!dec_neg) begin
               mul_a = sqx_ff;
               mul_b = K3 - (y_dec_b <<< 1);
            end else begin
               mul_a = sqy_ff;
               mul_b = (x_inc_b <<< 1) + K2;
            end
         end
         ST_IDLE, ST_INIT, ST_ACC, ST_E5, ST_EMIT: begin
            mul_a = '0;
            mul_b = '0;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = $signed({1'b0, mul_a}) * mul_b;

   // Mirrored pixel for the current index: bit 0 negates x, bit 1 negates y
   assign px_base = $signed({{(PIX_BITS-COORD_BITS){1'b0}}, ox_ff});
   assign py_base = $signed({{(PIX_BITS-COORD_BITS){1'b0}}, oy_ff});
   assign px_off  = $signed({{(PIX_BITS-CUR_BITS){1'b0}}, x_ff});
   assign py_off  = $signed({{(PIX_BITS-CUR_BITS){1'b0}}, y_ff});
   assign load_pix = (state_ff == ST_EMIT) && (!out_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      fx_in        = fx_ff;
      fy_in        = fy_ff;
      dec_in       = dec_ff;
      sqx_in       = sqx_ff;
      sqy_in       = sqy_ff;
      ox_in        = ox_ff;
      oy_in        = oy_ff;
      r2_in        = r2_ff;
      active_in    = active_ff;
      tmp_in       = tmp_ff;
      idx_in       = idx_ff;
      cmd_ready    = 1'b0;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_color_in = out_color_ff;
      out_last_in  = out_last_ff;
      out_done_in  = out_done_ff;

      unique case (state_ff)
         ST_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               if (cmd.kind == CMD_START) begin
                  ox_in    = cmd.center_x;
                  oy_in    = cmd.center_y;
                  sqx_in   = cmd.sq_x;
                  sqy_in   = cmd.sq_y;
                  x_in     = '0;
                  y_in     = CUR_BITS'(cmd.semi_y);
                  fx_in    = '0;
                  r2_in    = 1'b0;
                  state_in = ST_FY;
               end else if (!active_ff) begin
                  // drop: nothing left to draw
                  state_in = ST_IDLE;
               end else if (r1_go) begin
                  state_in = ST_R1;
               end else if (!r2_ff) begin
                  state_in = ST_E0;
               end else begin
                  state_in = ST_R2;
               end
            end
         end
         ST_FY: begin
            state_in = ST_INIT;
         end
         ST_INIT: begin
            fy_in    = {prod_ff[TERM_BITS-2:0], 1'b0};
            dec_in   = quarter_trunc(sqy_d - prod_d + sqx_q, sqx_ff[1:0]);
            idx_in   = '0;
            state_in = ST_EMIT;
         end
         ST_R1: begin
            x_in  = x_inc[CUR_BITS-1:0];
            fx_in = fx_step;
            if (dec_neg) begin
               state_in = ST_ACC;
            end else begin
               y_in     = y_dec;
               fy_in    = fy_step;
               state_in = ST_MAC_Y;
            end
         end
         ST_MAC_Y: begin
            dec_in   = dec_ff + prod_d;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            dec_in   = dec_ff + prod_d;
            idx_in   = '0;
            state_in = ST_EMIT;
         end
         ST_E0: begin
            state_in = ST_E1;
         end
         ST_E1: begin
            tmp_in   = prod_ff[OPB_BITS-1:0];
            state_in = ST_E2;
         end
         ST_E2: begin
            tmp_in   = prod_ff[OPB_BITS-1:0];
            dec_in   = sqy_q;
            state_in = ST_E3;
         end
         ST_E3: begin
            dec_in   = dec_ff + prod_d;
            state_in = ST_E4;
         end
         ST_E4: begin
            dec_in   = dec_ff + prod_d;
            state_in = ST_E5;
         end
         ST_E5: begin
            dec_in   = quarter_trunc(dec_ff - prod_d, sqy_ff[1:0]);
            r2_in    = 1'b1;
            state_in = ST_R2;
         end
         ST_R2: begin
            y_in  = y_dec;
            fy_in = fy_step;
            if (!dec_neg) begin
               state_in = ST_ACC;
            end else begin
               x_in     = x_inc[CUR_BITS-1:0];
               fx_in    = fx_step;
               state_in = ST_MAC_Y;
            end
         end
         ST_EMIT: begin
            if (load_pix) begin
               out_valid_in = 1'b1;
               out_x_in     = idx_ff[0] ? px_base - px_off : px_base + px_off;
               out_y_in     = idx_ff[1] ? py_base - py_off : py_base + py_off;
               out_color_in = draw_color;
               out_last_in  = (idx_ff == 2'd3);
               out_done_in  = !more;
               idx_in       = idx_ff + 1'b1;
               if (idx_ff == 2'd3) begin
                  active_in = more;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         x_ff         <= '0;
         y_ff         <= '0;
         fx_ff        <= '0;
         fy_ff        <= '0;
         dec_ff       <= '0;
         sqx_ff       <= '0;
         sqy_ff       <= '0;
         ox_ff        <= '0;
         oy_ff        <= '0;
         r2_ff        <= 1'b0;
         active_ff    <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         fx_ff        <= fx_in;
         fy_ff        <= fy_in;
         dec_ff       <= dec_in;
         sqx_ff       <= sqx_in;
         sqy_ff       <= sqy_in;
         ox_ff        <= ox_in;
         oy_ff        <= oy_in;
         r2_ff        <= r2_in;
         active_ff    <= active_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff      <= prod_in;
      tmp_ff       <= tmp_in;
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_color_ff <= out_color_in;
      out_last_ff  <= out_last_in;
      out_done_ff  <= out_done_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign pixel_x      = out_x_ff;
   assign pixel_y      = out_y_ff;
   assign pixel_color  = out_color_ff;
   assign last_of_step = out_last_ff;
   assign curve_done   = out_done_ff;

endmodule

### rtl/core/midpoint_ellipse_rasterizer.sv
// Midpoint ellipse rasterizer top level. For a start, a step or a step that enters region 2
// the back end works on the shared multiplier, then emits one pixel per cycle while the
// pixel channel does not stall it; a dropped step emits nothing.
// Synchronous active-high reset idles the block, empties the queue, sets color to 15.
// Depends on mer_pkg, mer_front, mer_fifo, mer_back and the defines header.
`include "midpoint_ellipse_rasterizer_defines.svh"

module midpoint_ellipse_rasterizer #(
   parameter int QUEUE_DEPTH = mer_pkg::QUEUE_DEPTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_action,
   input  logic [mer_pkg::COORD_BITS-1:0]        req_center_x,
   input  logic [mer_pkg::COORD_BITS-1:0]        req_center_y,
   input  logic [mer_pkg::SEMI_BITS-1:0]         req_semi_x,
   input  logic [mer_pkg::SEMI_BITS-1:0]         req_semi_y,
   // pixel channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [mer_pkg::PIX_BITS-1:0]   rsp_pixel_x,
   output logic signed [mer_pkg::PIX_BITS-1:0]   rsp_pixel_y,
   output logic [mer_pkg::COLOR_BITS-1:0]        rsp_pixel_color,
   output logic                                  rsp_last_of_step,
   output logic                                  rsp_curve_done,
   // color register
   input  logic                                  csr_write_en,
   input  logic [mer_pkg::COLOR_BITS-1:0]        csr_write_data
);
   import mer_pkg::*;

   logic [COLOR_BITS-1:0] color_ff, color_in;
   logic                  front_valid, front_ready;
   cmd_type               front_cmd;
   logic                  queue_valid, queue_ready;
   cmd_type               queue_cmd;
   logic [1:0]            rsp_idx_ff, rsp_idx_in;

   // Color register: the user must write it only while idle (not enforced here), sampled at pixel emission
   always_comb begin
      color_in = color_ff;
      if (csr_write_en) begin
         color_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff <= COLOR_RESET;
      end else begin
         color_ff <= color_in;
      end
   end

   // Front: hold one request, classify it, square the semi-axes
   mer_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_action   (req_action),
      .req_center_x (req_center_x),
      .req_center_y (req_center_y),
      .req_semi_x   (req_semi_x),
      .req_semi_y   (req_semi_y),
      .cmd_valid    (front_valid),
      .cmd_ready    (front_ready),
      .cmd          (front_cmd)
   );

   // Queue: decouple request intake from the iteration and pixel drain
   mer_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_cmd),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_data   (queue_cmd)
   );

   // Back: set up or advance the curve, then emit four mirrored pixels
   mer_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_valid    (queue_valid),
      .cmd_ready    (queue_ready),
      .cmd          (queue_cmd),
      .draw_color   (color_ff),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .pixel_x      (rsp_pixel_x),
      .pixel_y      (rsp_pixel_y),
      .pixel_color  (rsp_pixel_color),
      .last_of_step (rsp_last_of_step),
      .curve_done   (rsp_curve_done)
   );

   // Track the pixel position within a step as seen on the output channel
   always_comb begin
      rsp_idx_in = rsp_idx_ff;
      if (rsp_valid && rsp_ready) begin
         rsp_idx_in = rsp_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_idx_ff <= '0;
      end else begin
         rsp_idx_ff <= rsp_idx_in;
      end
   end

   // The four pixels of a step leave back to back once the first is taken
   `MER_ASSERT_NEXT(a_step_burst, rsp_valid && rsp_ready && !rsp_last_of_step, rsp_valid && (rsp_curve_done == $past(rsp_curve_done)), "step pixels broken up or done flag changed")
   // Last flag marks exactly every fourth delivered pixel
   `MER_ASSERT_NOW(a_last_slot, rsp_valid, rsp_last_of_step == (rsp_idx_ff == 2'd3), "last_of_step out of place")
   // Pixels 0/1 and 2/3 are mirrored in x only and share their row
   `MER_ASSERT_NEXT(a_row_pair, rsp_valid && rsp_ready && !rsp_idx_ff[0], rsp_pixel_y == $past(rsp_pixel_y), "mirrored pair row mismatch")

endmodule
